[hw/rtl/stcomp_pkg.sv]
// ----------------------------------------------------------------------------
// stcomp_pkg
// shared widths, codes and types of the temperature compensation block
// ----------------------------------------------------------------------------
package stcomp_pkg;

	localparam int TEMP_W    = 16;
	localparam int RAW_W     = 26;
	localparam int COEF_W    = 32;
	localparam int CFG_W     = 64;
	localparam int OUT_W     = 48;
	localparam int STAT_W    = 2;
	localparam int OUT_FRAC  = 16;
	localparam int RAW_FRAC  = 16;
	localparam int TEMP_FRAC = 8;
	// six coefficients below 2^31 each, |u| <= 1
	localparam int ACC_W     = 36;

	localparam int OFF_STEPS  = 5;
	localparam int GAIN_STEPS = 3;

	localparam int NUM_REGS  = 5;
	localparam int CFG_IDX_W = 3;
	localparam int TIN_W     = 48;
	localparam int TOUT_W    = 56;

	localparam int COEF_FRAC_BITS_DEF  = 30;
	localparam int TEMP_NORM_SHIFT_DEF = 7;

	localparam logic [CFG_IDX_W-1:0] REG_OFF_0_1  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_2_3  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_4_5  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_0_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_2_3 = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} div_flags_t;

endpackage

[hw/rtl/stcomp_horner_step.sv]
// ----------------------------------------------------------------------------
// stcomp_horner_step
// one horner step in two stages: multiply, then round, shift and add
// ----------------------------------------------------------------------------
module stcomp_horner_step import stcomp_pkg::*; #(
	parameter int SHIFT = TEMP_FRAC + TEMP_NORM_SHIFT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_in,
	input  logic signed [ACC_W-1:0]  acc_in,
	input  logic signed [TEMP_W-1:0] t_in,
	input  logic signed [COEF_W-1:0] coef,
	output logic                     vld_out,
	output logic signed [ACC_W-1:0]  acc_out,
	output logic signed [TEMP_W-1:0] t_out
);

	localparam int PW = ACC_W + TEMP_W;
	localparam logic signed [PW:0] RND = {{PW{1'b0}}, 1'b1} << (SHIFT - 1);

	logic signed [PW-1:0]     prod_s1;
	logic signed [TEMP_W-1:0] t_s1, t_s2;
	logic                     vld_s1, vld_s2;
	logic signed [ACC_W-1:0]  acc_s2;

	logic signed [PW:0]      psum;
	logic signed [PW:0]      pshift;
	logic signed [ACC_W-1:0] acc_nxt;

	always_comb begin
		psum    = {prod_s1[PW-1], prod_s1} + RND;
		pshift  = psum >>> SHIFT;
		acc_nxt = pshift[ACC_W-1:0] + {{(ACC_W-COEF_W){coef[COEF_W-1]}}, coef};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= acc_in * t_in;
			t_s1    <= t_in;
			acc_s2  <= acc_nxt;
			t_s2    <= t_s1;
		end
	end

	assign vld_out = vld_s2;
	assign acc_out = acc_s2;
	assign t_out   = t_s2;

endmodule

[hw/rtl/stcomp_divider.sv]
// ----------------------------------------------------------------------------
// stcomp_divider
// pipelined restoring divider on magnitudes, one quotient bit per stage
// ----------------------------------------------------------------------------
module stcomp_divider import stcomp_pkg::*; #(
	parameter int DVD_W = 57
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [DVD_W-1:0] dvd_in,
	input  logic [ACC_W-1:0] dvs_in,
	input  div_flags_t       flags_in,
	output logic             vld_out,
	output logic [DVD_W-1:0] quo_out,
	output div_flags_t       flags_out
);

	logic [ACC_W-1:0] rem_s   [1:DVD_W];
	logic [DVD_W-1:0] dq_s    [1:DVD_W];
	logic [ACC_W-1:0] dvs_s   [1:DVD_W];
	div_flags_t       flags_s [1:DVD_W];
	logic             vld_s   [1:DVD_W];

	for (genvar i = 0; i < DVD_W; i++) begin : g_stage
		logic [ACC_W-1:0] rem_c;
		logic [DVD_W-1:0] dq_c;
		logic [ACC_W-1:0] dvs_c;
		div_flags_t       flags_c;
		logic             vld_c;
		logic [ACC_W:0]   trial;
		logic [ACC_W:0]   diff;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_c   = '0;
			assign dq_c    = dvd_in;
			assign dvs_c   = dvs_in;
			assign flags_c = flags_in;
			assign vld_c   = vld_in;
		end else begin : g_next
			assign rem_c   = rem_s[i];
			assign dq_c    = dq_s[i];
			assign dvs_c   = dvs_s[i];
			assign flags_c = flags_s[i];
			assign vld_c   = vld_s[i];
		end

		always_comb begin
			trial = {rem_c, dq_c[DVD_W-1]};
			diff  = trial - {1'b0, dvs_c};
			ge    = (trial >= {1'b0, dvs_c});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]   <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
				dq_s[i+1]    <= {dq_c[DVD_W-2:0], ge};
				dvs_s[i+1]   <= dvs_c;
				flags_s[i+1] <= flags_c;
			end
		end
	end

	assign vld_out   = vld_s[DVD_W];
	assign quo_out   = dq_s[DVD_W];
	assign flags_out = flags_s[DVD_W];

endmodule

[hw/rtl/sensor_poly_temp_compensation.sv]
// ----------------------------------------------------------------------------
// sensor_poly_temp_compensation
// offset and gain polynomials in temperature by horner's rule, then
// (reading - offset) / gain as a saturated Q32.16 value
// ----------------------------------------------------------------------------
// stages: 10 horner stages, numerator, 57 divider stages (DVD_W at the
//   default coefficient format), saturation, output register
// throughput: one beat per cycle while the skid entry is free; the divider's
//   one-bit-per-stage pipe and the two-stage horner step (multiply, round and
//   add) set the depth
// reset: arst_n clears all valid bits and loads the coefficient registers
//   with zero offset and unity gain
module sensor_poly_temp_compensation import stcomp_pkg::*; #(
	parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
	parameter int TEMP_NORM_SHIFT = TEMP_NORM_SHIFT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// input beats
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// temperature [15:0], raw_reading [41:16], zero pad [47:42]
	input  logic [TIN_W-1:0]     s_axis_tdata,
	// output beats
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// corrected_value [47:0], status [49:48], zero pad [55:50]
	output logic [TOUT_W-1:0]    m_axis_tdata
);

	localparam int SHIFT    = TEMP_FRAC + TEMP_NORM_SHIFT;
	localparam int RAW_SH   = COEF_FRAC_BITS - RAW_FRAC;
	localparam int RAW_SH_W = RAW_W + RAW_SH;
	localparam int NUM_W    = ((RAW_SH_W > ACC_W) ? RAW_SH_W : ACC_W) + 1;
	localparam int DVD_W    = NUM_W + OUT_FRAC;
	localparam int OFF_LAT  = 2 * OFF_STEPS;
	localparam int GAIN_DLY = 2 * (OFF_STEPS - GAIN_STEPS);

	localparam logic [CFG_W-1:0] GAIN_RST = {{(CFG_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;
	localparam logic [DVD_W-1:0] LIM_POS  =
		{{(DVD_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic [DVD_W-1:0] LIM_NEG  =
		{{(DVD_W-OUT_W){1'b0}}, 1'b1, {(OUT_W-1){1'b0}}};

	// ------------------------------------------------------------------
	// coefficient registers
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] cfg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_OFF_0_1]  <= '0;
			cfg_q[REG_OFF_2_3]  <= '0;
			cfg_q[REG_OFF_4_5]  <= '0;
			cfg_q[REG_GAIN_0_1] <= GAIN_RST;
			cfg_q[REG_GAIN_2_3] <= '0;
		end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			// writes past the register list are dropped
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	// lower-order coefficient in the low half of each register
	logic signed [COEF_W-1:0] off_c  [OFF_STEPS+1];
	logic signed [COEF_W-1:0] gain_c [GAIN_STEPS+1];

	always_comb begin
		for (int k = 0; k <= OFF_STEPS; k++) begin
			off_c[k] = cfg_q[CFG_IDX_W'(k/2)][(k%2)*COEF_W +: COEF_W];
		end
		for (int k = 0; k <= GAIN_STEPS; k++) begin
			gain_c[k] = cfg_q[REG_GAIN_0_1 + CFG_IDX_W'(k/2)][(k%2)*COEF_W +: COEF_W];
		end
	end

	// ------------------------------------------------------------------
	// flow control: output register plus one skid entry; the pipe moves
	// whenever the skid entry is free
	// ------------------------------------------------------------------
	logic skid_vld_q;
	logic en;

	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	logic signed [TEMP_W-1:0] t_in;
	logic signed [RAW_W-1:0]  raw_in;

	assign t_in   = s_axis_tdata[TEMP_W-1:0];
	assign raw_in = s_axis_tdata[TEMP_W +: RAW_W];

	// ------------------------------------------------------------------
	// horner chains: offset of order five, gain of order three, in step
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0]  off_acc [OFF_STEPS+1];
	logic signed [TEMP_W-1:0] off_t   [OFF_STEPS+1];
	logic                     off_v   [OFF_STEPS+1];
	logic signed [ACC_W-1:0]  gn_acc  [GAIN_STEPS+1];

	assign off_acc[0] = ACC_W'(off_c[OFF_STEPS]);
	assign off_t[0]   = t_in;
	assign off_v[0]   = s_axis_tvalid && s_axis_tready;
	assign gn_acc[0]  = ACC_W'(gain_c[GAIN_STEPS]);

	for (genvar j = 0; j < OFF_STEPS; j++) begin : g_off
		stcomp_horner_step #(.SHIFT(SHIFT)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (off_v[j]),
			.acc_in  (off_acc[j]),
			.t_in    (off_t[j]),
			.coef    (off_c[OFF_STEPS-1-j]),
			.vld_out (off_v[j+1]),
			.acc_out (off_acc[j+1]),
			.t_out   (off_t[j+1])
		);
	end

	for (genvar j = 0; j < GAIN_STEPS; j++) begin : g_gain
		stcomp_horner_step #(.SHIFT(SHIFT)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (off_v[j]),
			.acc_in  (gn_acc[j]),
			.t_in    (off_t[j]),
			.coef    (gain_c[GAIN_STEPS-1-j]),
			.vld_out (),
			.acc_out (gn_acc[j+1]),
			.t_out   ()
		);
	end

	// gain waits for the longer offset chain, reading waits for both
	logic signed [ACC_W-1:0] gain_dly_s [1:GAIN_DLY];
	logic signed [RAW_W-1:0] raw_dly_s  [1:OFF_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			gain_dly_s[1] <= gn_acc[GAIN_STEPS];
			for (int i = 2; i <= GAIN_DLY; i++) begin
				gain_dly_s[i] <= gain_dly_s[i-1];
			end
			raw_dly_s[1] <= raw_in;
			for (int i = 2; i <= OFF_LAT; i++) begin
				raw_dly_s[i] <= raw_dly_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// numerator stage: r * 2^(frac - 16) - offset, to sign and magnitude
	// ------------------------------------------------------------------
	logic signed [NUM_W-1:0] num;
	logic [NUM_W-1:0]        num_mag;
	logic [ACC_W-1:0]        gain_mag;
	logic signed [ACC_W-1:0] gain_fin;

	assign gain_fin = gain_dly_s[GAIN_DLY];

	always_comb begin
		num      = (NUM_W'(raw_dly_s[OFF_LAT]) <<< RAW_SH) - NUM_W'(off_acc[OFF_STEPS]);
		num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		gain_mag = gain_fin[ACC_W-1] ? ACC_W'(-gain_fin) : ACC_W'(gain_fin);
	end

	logic [DVD_W-1:0] dvd_sn;
	logic [ACC_W-1:0] dvs_sn;
	div_flags_t       flags_sn;
	logic             vld_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else if (en) begin
			vld_sn <= off_v[OFF_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_sn        <= {num_mag, {OUT_FRAC{1'b0}}};
			dvs_sn        <= gain_mag;
			flags_sn.neg  <= num[NUM_W-1] ^ gain_fin[ACC_W-1];
			flags_sn.zero <= (gain_fin == '0);
		end
	end

	// ------------------------------------------------------------------
	// divider
	// ------------------------------------------------------------------
	logic             div_vld;
	logic [DVD_W-1:0] quo;
	div_flags_t       div_flags;

	stcomp_divider #(.DVD_W(DVD_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (vld_sn),
		.dvd_in    (dvd_sn),
		.dvs_in    (dvs_sn),
		.flags_in  (flags_sn),
		.vld_out   (div_vld),
		.quo_out   (quo),
		.flags_out (div_flags)
	);

	// ------------------------------------------------------------------
	// saturation stage: sign back on, clamp to 48 bits, zero-gain case
	// ------------------------------------------------------------------
	logic [OUT_W-1:0] sat_value;
	status_t          sat_status;

	always_comb begin
		sat_status = ST_OK;
		priority if (div_flags.zero) begin
			sat_value  = '0;
			sat_status = ST_ZERO;
		end else if (div_flags.neg && quo > LIM_NEG) begin
			sat_value  = LIM_NEG[OUT_W-1:0];
			sat_status = ST_SAT;
		end else if (!div_flags.neg && quo > LIM_POS) begin
			sat_value  = LIM_POS[OUT_W-1:0];
			sat_status = ST_SAT;
		end else if (div_flags.neg) begin
			sat_value  = -quo[OUT_W-1:0];
		end else begin
			sat_value  = quo[OUT_W-1:0];
		end
	end

	logic [OUT_W-1:0] value_sr;
	status_t          status_sr;
	logic             vld_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else if (en) begin
			vld_sr <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_sr  <= sat_value;
			status_sr <= sat_status;
		end
	end

	// ------------------------------------------------------------------
	// output register and skid entry
	// ------------------------------------------------------------------
	logic [OUT_W-1:0] out_value_q, skid_value_q;
	status_t          out_status_q, skid_status_q;
	logic             out_vld_q;
	logic             pop;

	assign pop = out_vld_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			// pipe is frozen, drain the skid entry first
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || pop) begin
			out_vld_q <= vld_sr;
		end else if (vld_sr) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_value_q  <= skid_value_q;
				out_status_q <= skid_status_q;
			end
		end else if (!out_vld_q || pop) begin
			out_value_q  <= value_sr;
			out_status_q <= status_sr;
		end else begin
			skid_value_q  <= value_sr;
			skid_status_q <= status_sr;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(TOUT_W-OUT_W-STAT_W){1'b0}}, out_status_q, out_value_q};

`ifndef NO_ASSERTIONS
	// skid entry only fills behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry valid without output beat");

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_status_q == ST_OK || out_status_q == ST_SAT
			|| out_status_q == ST_ZERO))
		else $error("bad status code");

	// zero gain always returns a zero value
	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_status_q == ST_ZERO) |-> (out_value_q == '0))
		else $error("zero gain with nonzero value");

	// a saturated beat sits at one of the two range limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_status_q == ST_SAT) |->
		(out_value_q == LIM_POS[OUT_W-1:0] || out_value_q == LIM_NEG[OUT_W-1:0]))
		else $error("saturated beat not at a limit");
`endif

endmodule

[verif/tb_sensor_poly_temp_compensation_chk.sv]
// ----------------------------------------------------------------------------
// tb_sensor_poly_temp_compensation_chk
// watches the config port and both streams, predicts every output beat of
// the compensation block and compares it field by field
// ----------------------------------------------------------------------------
module tb_sensor_poly_temp_compensation_chk import stcomp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [TIN_W-1:0]     s_axis_tdata,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [TOUT_W-1:0]    m_axis_tdata,
	output int                   errors,
	output int                   pending,
	output int                   checked,
	output int                   sat_seen,
	output int                   zero_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     STEP_SH = TEMP_FRAC + TEMP_NORM_SHIFT_DEF;
	localparam longint VAL_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
	localparam longint VAL_MIN = -VAL_MAX - 1;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		status_t          status;
	} comp_res_t;

	logic [CFG_W-1:0] coef_regs [NUM_REGS];
	comp_res_t        comp_q [$];

	function automatic longint coef_of(int k);
		logic [CFG_W-1:0] r;
		r = coef_regs[k >> 1];
		return (k & 1) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
	endfunction

	// acc * u rounded half up, then add the next coefficient
	function automatic longint horner(longint acc, longint t, longint nxt);
		return ((acc * t + (64'sd1 <<< (STEP_SH - 1))) >>> STEP_SH) + nxt;
	endfunction

	function automatic comp_res_t compensate(logic [TEMP_W-1:0] tb, logic [RAW_W-1:0] rb);
		longint    t, r, off, gain, num, q;
		comp_res_t res;
		t = longint'($signed(tb));
		r = longint'($signed(rb));
		off = coef_of(5);
		for (int k = 4; k >= 0; k--) off = horner(off, t, coef_of(k));
		gain = coef_of(9);
		for (int k = 8; k >= 6; k--) gain = horner(gain, t, coef_of(k));
		res.status = ST_OK;
		if (gain == 0) begin
			res.value  = '0;
			res.status = ST_ZERO;
			return res;
		end
		num = r * (64'sd1 <<< (COEF_FRAC_BITS_DEF - RAW_FRAC)) - off;
		q = (num * 65536) / gain;
		if (q > VAL_MAX) begin
			q = VAL_MAX;
			res.status = ST_SAT;
		end else if (q < VAL_MIN) begin
			q = VAL_MIN;
			res.status = ST_SAT;
		end
		res.value = q[OUT_W-1:0];
		return res;
	endfunction

	task automatic report(string what, longint exp_v, longint got_v);
		$display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		sat_seen = 0;
		zero_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		comp_res_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				coef_regs[i] <= (i == int'(REG_GAIN_0_1)) ?
					(64'd1 << COEF_FRAC_BITS_DEF) : '0;
		end else begin
			if (cfg_we && cfg_index < NUM_REGS) coef_regs[cfg_index] <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				comp_q.push_back(compensate(s_axis_tdata[15:0], s_axis_tdata[41:16]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (comp_q.size() == 0) begin
					report("unexpected beat", 0, longint'(m_axis_tdata));
				end else begin
					exp_r = comp_q.pop_front();
					checked++;
					if (exp_r.status == ST_SAT) sat_seen++;
					if (exp_r.status == ST_ZERO) zero_seen++;
					if (m_axis_tdata[47:0] !== exp_r.value)
						report("corrected_value", longint'(exp_r.value),
							longint'(m_axis_tdata[47:0]));
					if (m_axis_tdata[49:48] !== exp_r.status)
						report("status", longint'(exp_r.status),
							longint'(m_axis_tdata[49:48]));
					if (m_axis_tdata[55:50] !== '0)
						report("pad", 0, longint'(m_axis_tdata[55:50]));
				end
			end
			pending <= comp_q.size();
		end
	end

endmodule

[verif/tb_sensor_poly_temp_compensation.sv]
// ----------------------------------------------------------------------------
// tb_sensor_poly_temp_compensation
// drives temperature and reading beats through several coefficient sets
// (reset, zero gain, tiny gain, extremes, realistic and random) with random
// idling on both sides; a checker module predicts and compares every beat
// ----------------------------------------------------------------------------
module tb_sensor_poly_temp_compensation import stcomp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT      = 200000;
	localparam int DRAIN_WAIT = 100;   // beyond the depth of the pipe
	localparam int HOLD_LEN   = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// temperature [15:0], raw_reading [41:16], zero pad [47:42]
	logic [TIN_W-1:0]     s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// corrected_value [47:0], status [49:48], zero pad [55:50]
	logic [TOUT_W-1:0]    m_axis_tdata;

	int errors, pending, checked, sat_seen, zero_seen;
	int sent_cnt;
	int cycles;
	int cfg_sets;
	bit quiet;       // no idling on either side while set
	bit held;
	int hold_left;

	sensor_poly_temp_compensation i_dut (.*);

	tb_sensor_poly_temp_compensation_chk i_chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off so the pipe backs up
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (!held && sent_cnt >= 300) begin
				held = 1'b1;
				hold_left = HOLD_LEN;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(0, 99) >= 35);
			end
		end
	end

	// one input beat; entered and left at a falling edge
	task automatic send_beat(logic [TEMP_W-1:0] temp, logic [RAW_W-1:0] raw);
		while (!quiet && $urandom_range(0, 99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, raw, temp};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent_cnt++;
		@(negedge clk);
	endtask

	// stop offering, wait for every result and the pipe to empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic load_coefs(logic [CFG_W-1:0] o01, logic [CFG_W-1:0] o23,
		logic [CFG_W-1:0] o45, logic [CFG_W-1:0] g01, logic [CFG_W-1:0] g23);
		drain();
		write_reg(REG_OFF_0_1, o01);
		write_reg(REG_OFF_2_3, o23);
		write_reg(REG_OFF_4_5, o45);
		write_reg(REG_GAIN_0_1, g01);
		write_reg(REG_GAIN_2_3, g23);
		cfg_we <= 1'b0;
		cfg_sets++;
	endtask

	// small signed Q2.30 coefficient, magnitude below 2^bits
	function automatic logic [31:0] small_coef(int bits);
		int v;
		v = int'($urandom_range(0, (1 << bits) - 1));
		return $urandom_range(0, 1) ? 32'(-v) : 32'(v);
	endfunction

	// mostly within the sensor range, sometimes any bit pattern
	task automatic random_beat();
		logic [TEMP_W-1:0] temp;
		logic [RAW_W-1:0]  raw;
		if ($urandom_range(0, 9) < 8) begin
			temp = 16'($urandom_range(0, 29440) - 8960);
			raw  = 26'($urandom_range(0, 33554432) - 16777216);
		end else begin
			temp = 16'($urandom);
			raw  = 26'($urandom);
		end
		send_beat(temp, raw);
	endtask

	task automatic directed_set();
		send_beat(16'sd0, 26'sd0);
		send_beat(-16'sd8960, 26'sd16777216);
		send_beat(16'sd20480, -26'sd16777216);
		send_beat(16'h8000, 26'h1FFFFFF);
		send_beat(16'h7FFF, 26'h2000000);
		send_beat(16'hFFFF, 26'h3FFFFFF);
	endtask

	initial begin
		logic [CFG_W-1:0] g01;
		cycles = 0;
		sent_cnt = 0;
		cfg_sets = 0;
		quiet = 1'b0;
		held = 1'b0;
		hold_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset coefficients: zero offset, unity gain
		directed_set();
		// zero gain everywhere
		load_coefs(64'h1234_5678_9ABC_DEF0, '0, '0, '0, '0);
		directed_set();
		// one-lsb gain drives the quotient into saturation both ways
		load_coefs('0, '0, '0, 64'd1, '0);
		directed_set();
		// extremes: all ones, and max / min halves
		load_coefs('1, '1, '1, '1, '1);
		directed_set();
		load_coefs(64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000,
			64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000);
		// unknown index must be ignored
		write_reg(3'd5, '1);
		write_reg(3'd7, '1);
		cfg_we <= 1'b0;
		directed_set();

		// random part: realistic sets mostly, a single full random one
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 3) begin
				load_coefs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			end else begin
				g01 = {small_coef(26), 32'h4000_0000 + small_coef(28)};
				load_coefs({small_coef(30), small_coef(30)},
					{small_coef(24), small_coef(24)},
					{small_coef(20), small_coef(20)},
					g01, {small_coef(24), small_coef(26)});
			end
			quiet = (ph == 2);
			for (int i = 0; i < 190; i++) random_beat();
			quiet = 1'b0;
		end
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
		$display("covered %0d beats over %0d coefficient sets, %0d checked", sent_cnt,
			cfg_sets + 1, checked);
		$display("saturated results %0d, zero gain results %0d", sat_seen, zero_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/stcomp_pkg.sv
hw/rtl/stcomp_horner_step.sv
hw/rtl/stcomp_divider.sv
hw/rtl/sensor_poly_temp_compensation.sv
verif/tb_sensor_poly_temp_compensation_chk.sv
verif/tb_sensor_poly_temp_compensation.sv
